[hw/rtl/log_value_ascii_formatter_assert.svh]
// ----------------------------------------------------------------------------
// Log value formatter assertion macros
// Shared concurrent assertion forms for the formatter checker.
// ----------------------------------------------------------------------------
`ifndef LOG_VALUE_ASCII_FORMATTER_ASSERT_SVH
`define LOG_VALUE_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define LVAF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define LVAF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checks the cycle after reset is seen.
`define LVAF_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lvaf_pkg.sv]
// ----------------------------------------------------------------------------
// Log value formatter package
// Format codes, ASCII constants, record descriptor and conversion helpers.
// ----------------------------------------------------------------------------
package lvaf_pkg;

   localparam logic [2:0] FMT_UDEC = 3'd0;
   localparam logic [2:0] FMT_SDEC = 3'd1;
   localparam logic [2:0] FMT_HEX2 = 3'd2;
   localparam logic [2:0] FMT_HEX4 = 3'd3;
   localparam logic [2:0] FMT_HEX8 = 3'd4;
   localparam logic [2:0] FMT_CHAR = 3'd5;

   localparam logic [3:0] COLOR_NONE    = 4'd0;
   localparam logic [3:0] COLOR_DEFAULT = 4'd1;
   localparam logic [3:0] COLOR_FIRST   = 4'd2;
   localparam logic [3:0] COLOR_LAST    = 4'd9;

   localparam int VAL_W       = 32;
   localparam int DEC_DIGITS  = 10;
   localparam int BCD_W       = 4 * DEC_DIGITS;
   localparam int BITS_PER_CY = 4;
   localparam int CONV_CYCLES = VAL_W / BITS_PER_CY;

   localparam logic [7:0] ASCII_ESC      = 8'h1B;
   localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;
   localparam logic [7:0] ASCII_THREE    = 8'h33;
   localparam logic [7:0] ASCII_M        = 8'h6D;
   localparam logic [7:0] ASCII_MINUS    = 8'h2D;
   localparam logic [7:0] ASCII_HEX_OFS  = 8'h37; // 'A' - 10

   localparam logic [2:0] PLEN_NONE    = 3'd0;
   localparam logic [2:0] PLEN_DEFAULT = 3'd4;
   localparam logic [2:0] PLEN_COLOR   = 3'd5;

   // One queued record, fully classified
   typedef struct packed {
      logic [2:0]       fmt;
      logic [3:0]       color;
      logic [2:0]       plen;
      logic             neg;
      logic [3:0]       ndig;
      logic [4:0]       len;
      logic [VAL_W-1:0] value;
      logic [BCD_W-1:0] bcd;
   } rec_type;

   // One double-dabble step: add 3 to digits of 5 or more, shift in one bit
   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                input logic bit_in);
      logic [BCD_W-1:0] adj;
      logic [3:0]       dig;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         dig = bcd[4*i +: 4];
         if (dig >= 4'd5) begin
            dig = dig + 4'd3;
         end
         adj[4*i +: 4] = dig;
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return ASCII_ZERO + {4'd0, nib};
      end
      return ASCII_HEX_OFS + {4'd0, nib};
   endfunction

endpackage

[hw/rtl/log_value_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// Log value ASCII formatter
// Turns one log record into ASCII bytes with an optional ANSI color prefix.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_format, req_value, req_color and raise start; the
//    record transfers at a clock edge where start is high and busy is low.
//  - Result: one byte per cycle on rsp_out_byte with rsp_valid high for that
//    cycle; rsp_last marks the final byte. The receiver cannot stall, so every
//    strobed byte is a completed transfer. Records with no bytes (unused format
//    and no prefix) produce nothing.
//  - Config: csr_we writes csr_wdata into color_enable (reset value 1). Write
//    only while no record is in flight.
// Timing:
//  - Hex and char records enter the queue on the accept edge; the first byte
//    leaves through the back end's output register once earlier records are
//    sent. Decimal records run a BCD conversion (4 bits per cycle) and then
//    one queue write, which waits while the queue is full. The back end sends
//    one byte per cycle while the queue holds a record, up to 16 per record.
//  - A two-entry queue lets the front convert the next record while the back
//    end still sends the previous one.
// Reset: synchronous, clears queue, sequencers and the result strobe.
// ----------------------------------------------------------------------------
module log_value_ascii_formatter
   import lvaf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_format,
   input  logic [VAL_W-1:0] req_value,
   input  logic [3:0]       req_color,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic    color_enable_ff, color_enable_in;
   logic    q_push, q_pop, q_full, q_empty;
   rec_type q_wdata, q_head;

   // Single config bit
   assign color_enable_in = csr_we ? csr_wdata : color_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_enable_ff <= 1'b1;
      end else begin
         color_enable_ff <= color_enable_in;
      end
   end

   // Classify and convert
   lvaf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .color_enable (color_enable_ff),
      .start        (start),
      .busy         (busy),
      .req_format   (req_format),
      .req_value    (req_value),
      .req_color    (req_color),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   // Decouples conversion from byte output
   lvaf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Serialize bytes
   lvaf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .empty        (q_empty),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

[hw/rtl/lvaf_front.sv]
// ----------------------------------------------------------------------------
// Log value formatter front end
// Accepts records, filters color, converts decimal values to BCD, queues.
// ----------------------------------------------------------------------------
module lvaf_front
   import lvaf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             color_enable,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_format,
   input  logic [VAL_W-1:0] req_value,
   input  logic [3:0]       req_color,
   input  logic             q_full,
   output logic             q_push,
   output rec_type          q_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;
   localparam logic [2:0] CNT_LAST = 3'(CONV_CYCLES - 1);

   logic [1:0]       state_ff, state_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [VAL_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   rec_type          hold_ff, hold_in;

   logic             accept, is_dec, neg;
   logic [3:0]       col_eff;
   logic [2:0]       plen;
   logic [3:0]       body_len;
   logic [VAL_W-1:0] mag;
   rec_type          direct;
   logic [3:0]       ndig;
   logic [BCD_W-1:0] bcd_step;
   logic [VAL_W-1:0] bin_step;

   assign busy   = (state_ff != ST_IDLE) | q_full;
   assign accept = start & ~busy;
   assign is_dec = (req_format == FMT_UDEC) | (req_format == FMT_SDEC);
   assign neg    = (req_format == FMT_SDEC) & req_value[VAL_W-1];
   assign mag    = neg ? (~req_value + VAL_W'(1)) : req_value;

   always_comb begin
      col_eff = COLOR_NONE;
      if (color_enable && req_color >= COLOR_DEFAULT && req_color <= COLOR_LAST) begin
         col_eff = req_color;
      end
      if (col_eff == COLOR_NONE) begin
         plen = PLEN_NONE;
      end else if (col_eff == COLOR_DEFAULT) begin
         plen = PLEN_DEFAULT;
      end else begin
         plen = PLEN_COLOR;
      end
   end

   always_comb begin
      case (req_format)
         FMT_HEX2: body_len = 4'd2;
         FMT_HEX4: body_len = 4'd4;
         FMT_HEX8: body_len = 4'd8;
         FMT_CHAR: body_len = 4'd1;
         default:  body_len = 4'd0;
      endcase
   end

   always_comb begin
      direct       = '0;
      direct.fmt   = req_format;
      direct.color = col_eff;
      direct.plen  = plen;
      direct.neg   = neg;
      direct.value = req_value;
      direct.len   = {2'b00, plen} + {1'b0, body_len};
   end

   // Significant decimal digits, at least one
   always_comb begin
      ndig = 4'd1;
      for (int i = 1; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            ndig = 4'(i + 1);
         end
      end
   end

   // Four bits per cycle
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int s = 0; s < BITS_PER_CY; s++) begin
         bcd_step = dd_step(bcd_step, bin_step[VAL_W-1]);
         bin_step = {bin_step[VAL_W-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      hold_in  = hold_ff;
      q_push   = 1'b0;
      q_data   = direct;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_dec) begin
                  hold_in  = direct;
                  bin_in   = mag;
                  bcd_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_CONV;
               end else begin
                  q_push = (direct.len != 5'd0);
               end
            end
         end
         ST_CONV: begin
            bin_in = bin_step;
            bcd_in = bcd_step;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            q_data      = hold_ff;
            q_data.bcd  = bcd_ff;
            q_data.ndig = ndig;
            q_data.len  = {2'b00, hold_ff.plen} + {4'd0, hold_ff.neg} + {1'b0, ndig};
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      hold_ff <= hold_in;
   end

endmodule

[hw/rtl/lvaf_fifo.sv]
// ----------------------------------------------------------------------------
// Log value formatter record queue
// Two-entry queue of classified records between front and back end.
// ----------------------------------------------------------------------------
module lvaf_fifo
   import lvaf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_data,
   input  logic    pop,
   output rec_type head,
   output logic    full,
   output logic    empty
);

   rec_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/lvaf_back.sv]
// ----------------------------------------------------------------------------
// Log value formatter back end
// Walks the head record byte by byte and drives the registered result.
// ----------------------------------------------------------------------------
module lvaf_back
   import lvaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  rec_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic [3:0]       idx_ff, idx_in;
   logic             valid_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic [7:0]       cur_byte;
   logic             cur_last;
   logic [3:0]       j, k, d;
   logic [2:0]       hd, hex_top;
   logic [BCD_W-1:0] bcd_sh;
   logic [VAL_W-1:0] val_sh;

   assign cur_last = ({1'b0, idx_ff} == (head.len - 5'd1));
   assign pop      = ~empty & cur_last;
   assign j        = idx_ff - {1'b0, head.plen};
   assign k        = j - {3'd0, head.neg};
   assign d        = head.ndig - 4'd1 - k;
   assign bcd_sh   = head.bcd >> {d, 2'b00};

   always_comb begin
      case (head.fmt)
         FMT_HEX2: hex_top = 3'd1;
         FMT_HEX4: hex_top = 3'd3;
         default:  hex_top = 3'd7;
      endcase
   end

   assign hd     = hex_top - j[2:0];
   assign val_sh = head.value >> {hd, 2'b00};

   always_comb begin
      cur_byte = ASCII_ZERO;
      if (idx_ff < {1'b0, head.plen}) begin
         case (idx_ff)
            4'd0: cur_byte = ASCII_ESC;
            4'd1: cur_byte = ASCII_LBRACKET;
            4'd2: cur_byte = (head.color == COLOR_DEFAULT) ? ASCII_ZERO : ASCII_THREE;
            4'd3: cur_byte = (head.color == COLOR_DEFAULT) ? ASCII_M
                             : ASCII_ZERO + {4'd0, head.color - COLOR_FIRST};
            default: cur_byte = ASCII_M;
         endcase
      end else begin
         case (head.fmt)
            FMT_UDEC, FMT_SDEC: begin
               if (head.neg && j == 4'd0) begin
                  cur_byte = ASCII_MINUS;
               end else begin
                  cur_byte = ASCII_ZERO + {4'd0, bcd_sh[3:0]};
               end
            end
            FMT_HEX2, FMT_HEX4, FMT_HEX8: cur_byte = hex_char(val_sh[3:0]);
            default:                      cur_byte = head.value[7:0];
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (!empty) begin
         idx_in = cur_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= ~empty;
      end
      byte_ff <= cur_byte;
      last_ff <= cur_last;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff & valid_ff;

endmodule

[hw/rtl/lvaf_checker.sv]
// ----------------------------------------------------------------------------
// Log value formatter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "log_value_ascii_formatter_assert.svh"

module lvaf_checker
   import lvaf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_format,
   input logic       rsp_valid,
   input logic       rsp_last
);

   logic dec_accept;

   // decimal transfer taken this cycle
   assign dec_accept = start && !busy &&
                       (req_format == FMT_UDEC || req_format == FMT_SDEC);

   `LVAF_ASSERT_RST(a_reset_quiet, !rsp_valid && !busy, "output or busy after reset")
   `LVAF_ASSERT_NOW(a_last_strobed, rsp_last, rsp_valid, "last without valid")
   `LVAF_ASSERT_NEXT(a_dec_busy, dec_accept, busy, "decimal conversion did not hold busy")

endmodule

bind log_value_ascii_formatter lvaf_checker u_lvaf_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Log value ASCII formatter testbench
// Sends log records (format, value, color) through the start/busy command
// port and checks every strobed output byte and its last flag against an
// in-bench formatter. Covers directed corner values, color prefix on and off,
// unused format and color codes, then three randomized phases that differ
// in sender idling.
// ----------------------------------------------------------------------------
module testbench
   import lvaf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // format codes the block leaves unused: they print no value bytes
   localparam logic [2:0] FMT_UNUSED_LO = 3'd6;
   localparam logic [2:0] FMT_UNUSED_HI = 3'd7;
   // color codes past the last color behave as no color
   localparam logic [3:0] COLOR_BAD_LO  = 4'd10;
   localparam logic [3:0] COLOR_BAD_HI  = 4'd15;

   // a decimal record is converted before its first byte and then sends up to
   // 16 bytes; SETTLE_CYCLES also covers a record that produced nothing at all
   localparam int SETTLE_CYCLES  = 40;
   localparam int STALL_LIMIT    = 1000;
   localparam int MAX_GAP        = 6;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [2:0]       req_format;
   logic [VAL_W-1:0] req_value;
   logic [3:0]       req_color;
   logic             rsp_valid;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last;
   logic             csr_we;
   logic             csr_wdata;

   out_char_type expected_chars[$];   // bytes still owed by the block, in order
   logic         color_en_model;      // bench copy of color_enable
   int           sender_idle_pct;     // chance of a gap before each transfer
   int           err_count;
   int           stall_cycles;

   log_value_ascii_formatter i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_format   (req_format),
      .req_value    (req_value),
      .req_color    (req_color),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Formatter prediction
   // ---------------------------------------------------------------------

   // Decimal digits without leading zeros; zero gives a single '0'.
   function automatic void add_decimal(inout logic [7:0] txt[$],
                                       input logic [31:0] mag);
      logic [7:0] rev[$];
      logic [31:0] rest;
      rest = mag;
      do begin
         rev.push_back(ASCII_ZERO + 8'(rest % 10));
         rest = rest / 10;
      end while (rest != 0);
      while (rev.size() != 0) begin
         txt.push_back(rev.pop_back());
      end
   endfunction

   // Low ndig nibbles as uppercase hex, most significant first.
   function automatic void add_hex(inout logic [7:0] txt[$],
                                   input logic [31:0] v, input int ndig);
      logic [3:0] nib;
      for (int i = ndig - 1; i >= 0; i--) begin
         nib = v[4*i +: 4];
         txt.push_back((nib < 4'd10) ? ASCII_ZERO + 8'(nib) : ASCII_HEX_OFS + 8'(nib));
      end
   endfunction

   // Builds the full record for one transfer and queues its bytes.
   function automatic void predict_record(input logic [2:0] fmt,
                                          input logic [31:0] v,
                                          input logic [3:0] col);
      logic [7:0]   txt[$];
      out_char_type oc;
      // color prefix: ESC [ 0 m or ESC [ 3 d m
      if (color_en_model && col >= COLOR_DEFAULT && col <= COLOR_LAST) begin
         txt.push_back(ASCII_ESC);
         txt.push_back(ASCII_LBRACKET);
         if (col == COLOR_DEFAULT) begin
            txt.push_back(ASCII_ZERO);
         end else begin
            txt.push_back(ASCII_THREE);
            txt.push_back(ASCII_ZERO + 8'(col - COLOR_FIRST));
         end
         txt.push_back(ASCII_M);
      end
      case (fmt)
         FMT_UDEC: add_decimal(txt, v);
         FMT_SDEC: begin
            if (v[31]) begin
               // magnitude wraps, so 0x80000000 prints -2147483648
               txt.push_back(ASCII_MINUS);
               add_decimal(txt, (~v) + 32'd1);
            end else begin
               add_decimal(txt, v);
            end
         end
         FMT_HEX2: add_hex(txt, v, 2);
         FMT_HEX4: add_hex(txt, v, 4);
         FMT_HEX8: add_hex(txt, v, 8);
         FMT_CHAR: txt.push_back(v[7:0]);
         default: ;
      endcase
      for (int k = 0; k < txt.size(); k++) begin
         oc.ch   = txt[k];
         oc.last = (k == txt.size() - 1);
         expected_chars.push_back(oc);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Output checking: the receiver never stalls, so every strobe is a
   // completed transfer and is matched against the oldest owed byte.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      out_char_type want;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected output byte %h last %b", rsp_out_byte, rsp_last);
            err_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_byte !== want.ch) begin
               $error("out_byte: expected %h, got %h", want.ch, rsp_out_byte);
               err_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles with neither an accepted request nor a byte.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One request transfer. start is left high on return so a following
   // request can go back to back; an idle gap or a drain lowers it.
   task automatic send_record(input logic [2:0] fmt, input logic [31:0] v,
                              input logic [3:0] col);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      start      <= 1'b1;
      req_format <= fmt;
      req_value  <= v;
      req_color  <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer happened at this edge
      predict_record(fmt, v, col);
   endtask

   // Sender holds off until every owed byte is out, then lets a record
   // that produced no bytes finish inside the block.
   task automatic drain_records();
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_color_enable(input logic en);
      csr_we    <= 1'b1;
      csr_wdata <= en;
      @(posedge clock);
      csr_we    <= 1'b0;
      color_en_model = en;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(0, 999);
         2: return -$urandom_range(1, 100000);
         default: begin
            case ($urandom_range(4))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'h7FFF_FFFF;
               default: return 32'd1000000000;
            endcase
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset value of color_enable is 1: corner values, every format and
   // every valid color code, plus some of the unused ones.
   task automatic test_directed_formats();
      send_record(FMT_UDEC, 32'd0,          COLOR_NONE);
      send_record(FMT_UDEC, 32'hFFFF_FFFF,  COLOR_DEFAULT);
      send_record(FMT_UDEC, 32'd1000000000, COLOR_FIRST);
      send_record(FMT_UDEC, 32'd7,          4'd3);
      send_record(FMT_SDEC, 32'h8000_0000,  4'd4);
      send_record(FMT_SDEC, 32'hFFFF_FFFF,  4'd5);
      send_record(FMT_SDEC, 32'h7FFF_FFFF,  4'd6);
      send_record(FMT_SDEC, 32'd0,          4'd7);
      send_record(FMT_HEX2, 32'h1234_56AB,  4'd8);
      send_record(FMT_HEX4, 32'hFFFF_12EF,  COLOR_LAST);
      send_record(FMT_HEX8, 32'hDEAD_BEEF,  COLOR_BAD_LO);
      send_record(FMT_HEX8, 32'h0000_0000,  COLOR_BAD_HI);
      send_record(FMT_CHAR, 32'hFFFF_FF00,  COLOR_NONE);
      send_record(FMT_CHAR, 32'h0000_00FF,  COLOR_DEFAULT);
      // unused formats: prefix only, or nothing at all
      send_record(FMT_UNUSED_LO, 32'h1234_5678, COLOR_NONE);
      send_record(FMT_UNUSED_HI, 32'hFFFF_FFFF, 4'd3);
      send_record(FMT_UNUSED_LO, 32'h0,         COLOR_DEFAULT);
      send_record(FMT_UDEC, 32'd4294967295, 4'd11);
      drain_records();
   endtask

   // color_enable 0 suppresses every prefix.
   task automatic test_color_disabled();
      write_color_enable(1'b0);
      send_record(FMT_SDEC, 32'hFFFF_FFFE, COLOR_DEFAULT);
      send_record(FMT_HEX4, 32'h0000_BEEF, COLOR_LAST);
      send_record(FMT_CHAR, 32'h0000_0041, 4'd5);
      send_record(FMT_UNUSED_HI, 32'h0,    4'd5);   // no bytes at all
      send_record(FMT_UDEC, 32'd9,         COLOR_NONE);
      drain_records();
   endtask

   // Mostly valid formats and colors with varied values; a few unused codes.
   task automatic test_random_records(input int count, input int idle_pct);
      logic [2:0] fmt;
      logic [3:0] col;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         fmt = ($urandom_range(99) < 90) ? 3'($urandom_range(0, 5))
                                         : 3'($urandom_range(6, 7));
         col = ($urandom_range(99) < 85) ? 4'($urandom_range(0, 9))
                                         : 4'($urandom_range(10, 15));
         send_record(fmt, pick_value(), col);
      end
      drain_records();
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_format      = FMT_UDEC;
      req_value       = '0;
      req_color       = COLOR_NONE;
      csr_we          = 1'b0;
      csr_wdata       = 1'b0;
      color_en_model  = 1'b1;
      sender_idle_pct = 15;
      err_count       = 0;
      stall_cycles    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_formats();
      test_color_disabled();
      write_color_enable(1'b1);
      test_random_records(50, 15);
      write_color_enable(1'b0);
      test_random_records(50, 56);
      write_color_enable(1'b1);
      test_random_records(50, 0);

      // drain_records already waited out the tail latency
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
